### design/fce_pkg.sv
// ----------------------------------------------------------------------------
// fce_pkg: filename character escaper package
// Shared constants, beat codes and helper functions of the escaper.
// ----------------------------------------------------------------------------
package fce_pkg;

  // character codes
  localparam logic [7:0] MarkChar  = 8'h2E;  // '.'
  localparam logic [3:0] DigitHigh = 4'h3;   // upper nibble of ASCII '0'..'9'

  // position of a result byte inside a four-byte escape
  localparam logic [1:0] BeatMark = 2'd0;
  localparam logic [1:0] BeatHund = 2'd1;
  localparam logic [1:0] BeatTens = 2'd2;
  localparam logic [1:0] BeatOnes = 2'd3;

  // decimal digits of one byte
  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  // letters, digits and underscore pass through
  function automatic logic is_name_char(input logic [7:0] b);
    logic res;
    res = ((b >= 8'h61) && (b <= 8'h7A)) ||
          ((b >= 8'h41) && (b <= 8'h5A)) ||
          ((b >= 8'h30) && (b <= 8'h39)) ||
          (b == 8'h5F);
    return res;
  endfunction

  // split a byte into three decimal digits
  function automatic digits_t to_digits(input logic [7:0] b);
    digits_t    d;
    logic [7:0] rem8;
    logic [6:0] rem;
    logic [14:0] prod;
    logic [6:0] tens10;
    // hundreds by compare, remainder stays below 100
    if (b >= 8'd200) begin
      d.hund = 4'd2;
      rem8   = b - 8'd200;
    end else if (b >= 8'd100) begin
      d.hund = 4'd1;
      rem8   = b - 8'd100;
    end else begin
      d.hund = 4'd0;
      rem8   = b;
    end
    rem    = rem8[6:0];
    // divide by ten through the reciprocal 205 / 2048, exact below 100
    prod   = 15'(rem) * 15'd205;
    d.tens = prod[14:11];
    tens10 = 7'(d.tens) * 7'd10;
    rem8   = 8'(rem - tens10);
    d.ones = rem8[3:0];
    return d;
  endfunction

endpackage

### design/fce_if.sv
// ----------------------------------------------------------------------------
// fce_if: escaper stream channels
// Valid/ready channels for raw input bytes and for escaped result bytes.
// ----------------------------------------------------------------------------

// raw byte channel
interface fce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// result byte channel
interface fce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       escaped;
  logic       last_of_run;

  modport source (output valid, output out_byte, output escaped, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input escaped, input last_of_run,
                  output ready);
endinterface

### design/filename_char_escaper_unit.sv
// ----------------------------------------------------------------------------
// filename_char_escaper_unit: filename character escaper
// Turns a byte stream into a filename-safe stream using decimal escapes.
// ----------------------------------------------------------------------------
// Usage
//   in_i  : one raw byte per request (valid/ready, taken when both are high)
//   out_o : result bytes with escaped and last_of_run flags
//   Letters, digits and underscore give one result byte; any other byte
//   gives four: '.', then hundreds, tens and ones digits in ASCII.
// Path of a request: the input register, then the output register.
// Throughput: one result byte per cycle while out_o is not stalled,
//   set by the single output register.
// The input register takes a new byte in the cycle its current byte hands
//   its last result to the output register, so requests flow back to back.
// Reset clears both valid flags and the beat counter; nothing is pending.
// When the receiver stalls, the output register holds its result and the
//   input register holds its byte; in_i.ready is high only while the input
//   register is empty or its byte hands its last result to the output.
// ----------------------------------------------------------------------------
module filename_char_escaper_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  fce_in_if.sink     in_i,
  fce_out_if.source  out_o
);

  // input register stage
  logic       a_valid_q, a_valid_d;
  logic [7:0] a_byte_q;
  logic [1:0] beat_q, beat_d;

  // result register stage
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_esc_q;
  logic       out_last_q;

  logic            a_name;
  logic            a_last;
  logic            out_load;
  logic            in_take;
  fce_pkg::digits_t a_dig;
  logic [7:0]      res_byte;

  // classify and split the held byte
  always_comb begin
    a_name = fce_pkg::is_name_char(a_byte_q);
    a_dig  = fce_pkg::to_digits(a_byte_q);
    a_last = a_name || (beat_q == fce_pkg::BeatOnes);
  end

  // pick the result byte for the current beat
  always_comb begin
    if (a_name) begin
      res_byte = a_byte_q;
    end else begin
      case (beat_q)
        fce_pkg::BeatMark: res_byte = fce_pkg::MarkChar;
        fce_pkg::BeatHund: res_byte = {fce_pkg::DigitHigh, a_dig.hund};
        fce_pkg::BeatTens: res_byte = {fce_pkg::DigitHigh, a_dig.tens};
        fce_pkg::BeatOnes: res_byte = {fce_pkg::DigitHigh, a_dig.ones};
        default:           res_byte = fce_pkg::MarkChar;
      endcase
    end
  end

  // handshake and stage control
  always_comb begin
    out_load   = a_valid_q && (!out_valid_q || out_o.ready);
    in_i.ready = !a_valid_q || (out_load && a_last);
    in_take    = in_i.valid && in_i.ready;

    a_valid_d = a_valid_q;
    if (in_take) begin
      a_valid_d = 1'b1;
    end else if (out_load && a_last) begin
      a_valid_d = 1'b0;
    end

    beat_d = beat_q;
    if (out_load) begin
      beat_d = a_last ? fce_pkg::BeatMark : beat_q + 2'd1;
    end

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      beat_q      <= fce_pkg::BeatMark;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_byte_q <= in_i.in_byte;
    end
    if (out_load) begin
      out_byte_q <= res_byte;
      out_esc_q  <= !a_name;
      out_last_q <= a_last;
    end
  end

  // output drive
  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.escaped     = out_esc_q;
  assign out_o.last_of_run = out_last_q;

  // a passthrough result is always a name character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_esc_q |-> out_last_q && fce_pkg::is_name_char(out_byte_q))
    else $error("passthrough result is not a name character");

  // the marker never closes an escape
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_esc_q && (out_byte_q == fce_pkg::MarkChar) |-> !out_last_q)
    else $error("escape marker flagged as last");

  // a mid-escape beat only exists for a held non-name byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q != fce_pkg::BeatMark |-> a_valid_q && !a_name)
    else $error("beat counter running without an escaped byte");

  // an accepted request is held in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> a_valid_q && (beat_q == fce_pkg::BeatMark))
    else $error("accepted request not held");

endmodule
